// ----- design/u2d_pkg.sv -----
// ----------------------------------------------------------------------------
// u2d_pkg: shared types and constants for the u32 to decimal ascii unit
// Holds digit types, widths and the control bundle of the digit cells.
// ----------------------------------------------------------------------------
package u2d_pkg;

    localparam int C_VALUE_W    = 32;
    localparam int C_DIGIT_W    = 4;
    localparam int C_NUM_DIGITS = 10;
    localparam int C_IDX_W      = $clog2(C_NUM_DIGITS);
    localparam int C_CNT_W      = $clog2(C_VALUE_W);
    localparam int C_CHAR_W     = 6;
    localparam int C_TDATA_W    = 8;

    localparam logic [C_CHAR_W-1:0]  C_ASCII_ZERO = 6'd48;
    localparam logic [C_DIGIT_W-1:0] C_ADJ_LIMIT  = 4'd5;
    localparam logic [C_DIGIT_W-1:0] C_ADJ_ADD    = 4'd3;
    localparam logic [C_CNT_W-1:0]   C_LAST_BIT   = C_CNT_W'(C_VALUE_W - 1);

    typedef logic [C_DIGIT_W-1:0]                    t_digit;
    typedef logic [C_NUM_DIGITS-1:0][C_DIGIT_W-1:0]  t_digit_vec;
    typedef logic [C_IDX_W-1:0]                      t_idx;

    // control of every cell in the chain
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

endpackage

// ----- design/u32_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// u32_to_decimal_ascii_unit: unsigned 32-bit to decimal ascii text
// Shift-add-3 conversion in a chain of ten bcd cells, then a digit emitter.
// ----------------------------------------------------------------------------
// conversion: one input bit shifted through the cell chain per cycle
// throughput: a new value is taken only after the last one has passed to the
//   emitter; the emitter sends one character per cycle while i_m_tready is
//   high (1 to 10 per value), in parallel with the next conversion
// reset: synchronous active-low, clears the sequencer and the emitter state
module u32_to_decimal_ascii_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [u2d_pkg::C_VALUE_W-1:0] i_s_tdata,  // [31:0] value
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [u2d_pkg::C_TDATA_W-1:0] o_m_tdata,  // [5:0] digit_char
    output logic                          o_m_tlast
);
    import u2d_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SHIFT = 3'b010,
        S_HOLD  = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [C_VALUE_W-1:0]  r_value;
    logic [C_VALUE_W-1:0]  n_value;
    logic [C_CNT_W-1:0]    r_bit_cnt;
    logic [C_CNT_W-1:0]    n_bit_cnt;
    logic                  w_accept;
    logic                  w_emit_ready;
    logic                  w_load;
    t_cell_ctrl            w_ctrl;
    logic [C_NUM_DIGITS-1:0] w_carry;
    logic                  w_overflow;
    t_digit_vec            w_digits;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = (r_state == S_HOLD) && w_emit_ready;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_value   = r_value;
        n_bit_cnt = r_bit_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state   = S_SHIFT;
                    n_value   = i_s_tdata;
                    n_bit_cnt = '0;
                end
            end
            S_SHIFT: begin
                n_value   = {r_value[C_VALUE_W-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt + 1'b1;
                if (r_bit_cnt == C_LAST_BIT) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_emit_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // cell chain, cell 0 holds the ones digit
    assign w_ctrl.clear = w_accept;
    assign w_ctrl.shift = (r_state == S_SHIFT);
    assign w_carry[0]   = r_value[C_VALUE_W-1];

    for (genvar g = 0; g < C_NUM_DIGITS; g++) begin : g_cell
        logic w_carry_out;

        u2d_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_carry (w_carry[g]),
            .o_carry (w_carry_out),
            .o_digit (w_digits[g])
        );

        if (g < C_NUM_DIGITS - 1) begin : g_link
            assign w_carry[g+1] = w_carry_out;
        end else begin : g_top
            assign w_overflow = w_carry_out;
        end
    end

    // character emitter
    u2d_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_digits   (w_digits),
        .o_ready    (w_emit_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SHIFT) && (r_bit_cnt == '0))
        else $error("accepted value did not start conversion");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> !w_overflow)
        else $error("carry out of top digit cell");

    a_load_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_m_tvalid)
        else $error("loaded digits not presented");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata >= 8'd48) && (o_m_tdata <= 8'd57))
        else $error("character outside decimal digit range");

endmodule

// ----- design/u2d_cell.sv -----
// ----------------------------------------------------------------------------
// u2d_cell: one bcd digit cell of the shift-add-3 chain
// Adds 3 when the digit is 5 or more, then shifts left taking the carry in
// from its lower neighbor and handing its top bit to the upper neighbor.
// ----------------------------------------------------------------------------
module u2d_cell (
    input  logic                i_clk,
    input  u2d_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_carry,
    output logic                o_carry,
    output u2d_pkg::t_digit     o_digit
);
    import u2d_pkg::*;

    t_digit r_digit;
    t_digit n_digit;
    t_digit w_adj;

    // add-3 correction and shift
    always_comb begin
        w_adj   = (r_digit >= C_ADJ_LIMIT) ? (r_digit + C_ADJ_ADD) : r_digit;
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.shift) begin
            n_digit = {w_adj[C_DIGIT_W-2:0], i_carry};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_carry = w_adj[C_DIGIT_W-1];
    assign o_digit = r_digit;

endmodule

// ----- design/u2d_emit.sv -----
// ----------------------------------------------------------------------------
// u2d_emit: digit emitter
// Takes the ten finished bcd digits, finds the most significant nonzero one
// and sends one ascii character per item down to the least significant.
// ----------------------------------------------------------------------------
module u2d_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  u2d_pkg::t_digit_vec           i_digits,
    output logic                          o_ready,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [u2d_pkg::C_TDATA_W-1:0] o_m_tdata,  // [5:0] digit_char
    output logic                          o_m_tlast
);
    import u2d_pkg::*;

    t_digit_vec         r_digits;
    t_idx               r_idx;
    t_idx               n_idx;
    logic               r_busy;
    logic               n_busy;
    t_idx               w_top;
    logic               w_final;
    logic [C_CHAR_W-1:0] w_char;

    // position of the most significant nonzero digit, zero gives position 0
    always_comb begin
        w_top = '0;
        for (int k = 0; k < C_NUM_DIGITS; k++) begin
            if (i_digits[k] != '0) begin
                w_top = C_IDX_W'(k);
            end
        end
    end

    assign w_final = r_busy && i_m_tready && (r_idx == '0);
    assign o_ready = !r_busy || w_final;

    // walk down from the top digit, one per taken item
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (i_load) begin
            n_busy = 1'b1;
            n_idx  = w_top;
        end else if (w_final) begin
            n_busy = 1'b0;
        end else if (r_busy && i_m_tready) begin
            n_idx = r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_digits <= i_digits;
        end
    end

    // ascii output
    assign w_char     = C_ASCII_ZERO + {{(C_CHAR_W-C_DIGIT_W){1'b0}}, r_digits[r_idx]};
    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = {{(C_TDATA_W-C_CHAR_W){1'b0}}, w_char};
    assign o_m_tlast  = (r_idx == '0);

endmodule
